@@ sv/pts_pkg.sv @@
// Shared types and codes for the priority task scheduler.
package pts_pkg;

  typedef enum logic [1:0] {
    ACT_READY    = 2'd0,
    ACT_ACQUIRE  = 2'd1,
    ACT_RELEASE  = 2'd2,
    ACT_SCHEDULE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_OWNER = 2'd1,
    ST_NO_TASK   = 2'd2
  } status_t;

  localparam int unsigned STAMP_W = 16;

  // Table sizes, fixed by the 5-bit task and 3-bit lock fields of the word
  localparam int unsigned MAX_TASKS = 32;
  localparam int unsigned NUM_LOCKS = 8;
  localparam int unsigned PRIO_BITS = 8;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture input word, decode action
    logic scan_clr;  // reset scan best and index
    logic scan_step; // evaluate one table entry
    logic commit;    // apply state update for the word
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_scan; // action uses a table scan
    logic scan_last; // current entry is the last one
  } sts_t;

endpackage

@@ sv/priority_task_scheduler_with_locks_top.sv @@
// Top level of the priority task scheduler with locks.
// Each word takes one result word. Make ready and acquire go from accept through
// decode to commit and the result; release that frees a lock and schedule scan the 32-entry
// task table one entry a cycle between decode and commit. A new word is accepted
// the cycle after the previous result has been taken.
module priority_task_scheduler_with_locks_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [4:0] in_task_id,
  input  logic [7:0] in_priority_req,
  input  logic [2:0] in_resource_id,
  input  logic       in_current_has_time,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_granted,
  output logic       out_next_valid,
  output logic [4:0] out_next_task,
  output logic       out_woken_valid,
  output logic [4:0] out_woken_task,
  output logic [1:0] out_status
);
  import pts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  pts_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_action(in_action), .in_task_id(in_task_id),
    .in_priority_req(in_priority_req), .in_resource_id(in_resource_id),
    .in_current_has_time(in_current_has_time),
    .out_granted(out_granted), .out_next_valid(out_next_valid),
    .out_next_task(out_next_task), .out_woken_valid(out_woken_valid),
    .out_woken_task(out_woken_task), .out_status(out_status)
  );

endmodule

@@ sv/pts_datapath.sv @@
// Scheduler state tables, sequential best-entry scan and result register.
module pts_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pts_pkg::cmd_t        cmd,
  output pts_pkg::sts_t        sts,
  input  logic [1:0]           in_action,
  input  logic [4:0]           in_task_id,
  input  logic [7:0]           in_priority_req,
  input  logic [2:0]           in_resource_id,
  input  logic                 in_current_has_time,
  output logic                 out_granted,
  output logic                 out_next_valid,
  output logic [4:0]           out_next_task,
  output logic                 out_woken_valid,
  output logic [4:0]           out_woken_task,
  output logic [1:0]           out_status
);
  import pts_pkg::*;

  localparam int unsigned TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;

  // State tables
  logic [PRIO_BITS-1:0] prio_r    [MAX_TASKS];
  logic [STAMP_W-1:0]   rord_r    [MAX_TASKS];
  logic [STAMP_W-1:0]   word_ord_r[MAX_TASKS];
  logic [LW-1:0]        wlock_r   [MAX_TASKS];
  logic [TW-1:0]        holder_r  [NUM_LOCKS];
  logic [MAX_TASKS-1:0] rmark_r, wmark_r;
  logic [NUM_LOCKS-1:0] held_r;
  logic                 run_pres_r, run_blk_r;
  logic [TW-1:0]        run_task_r;
  logic [STAMP_W-1:0]   cnt_r;

  // Captured word
  action_t              act_r;
  logic [TW-1:0]        tid_r;
  logic [PRIO_BITS-1:0] pri_r;
  logic [LW-1:0]        lock_r;
  logic                 time_r;

  // Scan state
  logic [TW-1:0]        idx_r;
  logic                 bv_r;
  logic [TW-1:0]        bi_r;
  logic [PRIO_BITS-1:0] bp_r;
  logic [STAMP_W-1:0]   ba_r;

  logic                 active;
  logic                 requeue;
  logic                 lock_ok;
  logic [STAMP_W-1:0]   cnt_eff;
  logic                 e_ok;
  logic [STAMP_W-1:0]   e_age;
  logic [PRIO_BITS-1:0] e_pri;

  // Result word for the current action
  logic                 granted_nxt;
  logic                 next_valid_nxt;
  logic [4:0]           next_task_nxt;
  logic                 woken_valid_nxt;
  logic [4:0]           woken_task_nxt;
  status_t              status_nxt;

  // Decode from captured word
  assign active  = run_pres_r && !run_blk_r;
  assign requeue = (act_r == ACT_SCHEDULE) && active && time_r;
  // Requeue stamp is taken before the scan, so ages see counter + 1
  assign cnt_eff = requeue ? cnt_r + STAMP_W'(1) : cnt_r;

  assign lock_ok = held_r[lock_r] && holder_r[lock_r] == run_task_r;
  assign sts.need_scan = (act_r == ACT_SCHEDULE) ||
                         (act_r == ACT_RELEASE && active && lock_ok);
  assign sts.scan_last = (idx_r == TW'(MAX_TASKS - 1));

  // Evaluate one entry; running task counts as ready when requeued
  always_comb begin
    e_pri = prio_r[idx_r];
    if (act_r == ACT_SCHEDULE) begin
      if (requeue && idx_r == run_task_r) begin
        e_ok  = 1'b1;
        e_age = STAMP_W'(1);
      end else begin
        e_ok  = rmark_r[idx_r];
        e_age = cnt_eff - rord_r[idx_r];
      end
    end else begin
      e_ok  = wmark_r[idx_r] && wlock_r[idx_r] == lock_r;
      e_age = cnt_r - word_ord_r[idx_r];
    end
  end

  // Form the result word from the decode and the scan winner
  always_comb begin
    granted_nxt     = 1'b0;
    next_valid_nxt  = 1'b0;
    next_task_nxt   = '0;
    woken_valid_nxt = 1'b0;
    woken_task_nxt  = '0;
    status_nxt      = ST_OK;
    case (act_r)
      ACT_ACQUIRE: begin
        if (!active) status_nxt = ST_NO_TASK;
        else if (!held_r[lock_r]) granted_nxt = 1'b1;
      end
      ACT_RELEASE: begin
        if (!active) begin
          status_nxt = ST_NO_TASK;
        end else if (!lock_ok) begin
          status_nxt = ST_NOT_OWNER;
        end else if (bv_r) begin
          woken_valid_nxt = 1'b1;
          woken_task_nxt  = 5'(bi_r);
        end
      end
      ACT_SCHEDULE: begin
        if (bv_r) begin
          next_valid_nxt = 1'b1;
          next_task_nxt  = 5'(bi_r);
        end
      end
      default: ;
    endcase
  end

  // Advance scan and capture word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= action_t'(in_action);
      tid_r  <= TW'(32'(in_task_id) % MAX_TASKS);
      pri_r  <= PRIO_BITS'(in_priority_req);
      lock_r <= LW'(32'(in_resource_id) % NUM_LOCKS);
      time_r <= in_current_has_time;
    end
    if (cmd.scan_clr) begin
      idx_r <= '0;
      bv_r  <= 1'b0;
    end else if (cmd.scan_step) begin
      if (e_ok && (!bv_r || e_pri > bp_r || (e_pri == bp_r && e_age > ba_r))) begin
        bv_r <= 1'b1;
        bi_r <= idx_r;
        bp_r <= e_pri;
        ba_r <= e_age;
      end
      if (!sts.scan_last) idx_r <= idx_r + TW'(1);
    end
  end

  // Commit the state update and register the result word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rmark_r    <= '0;
      wmark_r    <= '0;
      held_r     <= '0;
      run_pres_r <= 1'b0;
      run_blk_r  <= 1'b0;
      run_task_r <= '0;
      cnt_r      <= '0;
    end else if (cmd.commit) begin
      out_granted     <= granted_nxt;
      out_next_valid  <= next_valid_nxt;
      out_next_task   <= next_task_nxt;
      out_woken_valid <= woken_valid_nxt;
      out_woken_task  <= woken_task_nxt;
      out_status      <= status_nxt;
      case (act_r)
        ACT_READY: begin
          prio_r[tid_r] <= pri_r;
          if (!rmark_r[tid_r] && !wmark_r[tid_r] &&
              !(run_pres_r && run_task_r == tid_r)) begin
            rmark_r[tid_r] <= 1'b1;
            rord_r[tid_r]  <= cnt_r;
            cnt_r          <= cnt_r + STAMP_W'(1);
          end
        end
        ACT_ACQUIRE: begin
          if (active && !held_r[lock_r]) begin
            held_r[lock_r]   <= 1'b1;
            holder_r[lock_r] <= run_task_r;
          end else if (active) begin
            run_blk_r              <= 1'b1;
            wmark_r[run_task_r]    <= 1'b1;
            wlock_r[run_task_r]    <= lock_r;
            word_ord_r[run_task_r] <= cnt_r;
            cnt_r                  <= cnt_r + STAMP_W'(1);
          end
        end
        ACT_RELEASE: begin
          if (active && lock_ok) begin
            held_r[lock_r] <= 1'b0;
            if (bv_r) begin
              wmark_r[bi_r] <= 1'b0;
              rmark_r[bi_r] <= 1'b1;
              rord_r[bi_r]  <= cnt_r;
              cnt_r         <= cnt_r + STAMP_W'(1);
            end
          end
        end
        default: begin
          // Schedule: requeue, then take best ready task
          cnt_r     <= cnt_eff;
          run_blk_r <= 1'b0;
          if (requeue) rord_r[run_task_r] <= cnt_r;
          // Requeued task that wins the scan goes straight back to running
          if (requeue && !(bv_r && bi_r == run_task_r)) rmark_r[run_task_r] <= 1'b1;
          if (bv_r) begin
            rmark_r[bi_r] <= 1'b0;
            run_pres_r    <= 1'b1;
            run_task_r    <= bi_r;
          end else begin
            run_pres_r <= 1'b0;
          end
        end
      endcase
    end
  end

endmodule

@@ sv/pts_ctrl.sv @@
// Controller: handshake and sequencing of decode, scan and commit.
module pts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output pts_pkg::cmd_t cmd,
  input  pts_pkg::sts_t sts
);
  import pts_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DECODE, S_SCAN, S_COMMIT} state_t;

  state_t state_r, state_nxt;
  logic   ovalid_r, ovalid_nxt;
  logic   accept;

  // Accept only when idle and the result register is free
  assign in_stall  = !(state_r == S_IDLE && !ovalid_r);
  assign accept    = in_valid && !in_stall;
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt    = state_r;
    ovalid_nxt   = ovalid_r && out_stall;
    cmd          = '0;
    cmd.load     = accept;
    case (state_r)
      S_IDLE: if (accept) state_nxt = S_DECODE;
      S_DECODE: begin
        cmd.scan_clr = 1'b1;
        state_nxt    = sts.need_scan ? S_SCAN : S_COMMIT;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule
